>>> hdl/itp_pkg.sv
// Shared types, character codes and precedence helpers for the infix-to-postfix converter.
package itp_pkg;

  localparam int SYM_W = 8;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [2:0]       prec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MARK
  } state_t;

  typedef enum logic [1:0] {
    OP_FLUSH,
    OP_CLOSE,
    OP_OPER
  } op_t;

  localparam sym_t CH_CARET = 8'h5E;
  localparam sym_t CH_STAR  = 8'h2A;
  localparam sym_t CH_SLASH = 8'h2F;
  localparam sym_t CH_PLUS  = 8'h2B;
  localparam sym_t CH_MINUS = 8'h2D;
  localparam sym_t CH_OPEN  = 8'h28;
  localparam sym_t CH_CLOSE = 8'h29;

  // Precedence shifted up by one so that "anything else" is the lowest code.
  localparam prec_t PREC_NONE = 3'd0;
  localparam prec_t PREC_ADD  = 3'd2;
  localparam prec_t PREC_MUL  = 3'd3;
  localparam prec_t PREC_POW  = 3'd4;

  function automatic prec_t prec_of(input sym_t c);
    prec_t p;
    if (c == CH_CARET) p = PREC_POW;
    else if (c == CH_STAR || c == CH_SLASH) p = PREC_MUL;
    else if (c == CH_PLUS || c == CH_MINUS) p = PREC_ADD;
    else p = PREC_NONE;
    return p;
  endfunction

  function automatic logic is_operand(input sym_t c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

>>> hdl/itp_if.sv
// Valid/ready channel interfaces for the infix input and postfix output streams.
interface itp_sym_if;
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [itp_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface itp_post_if;
  logic                   valid;
  logic                   ready;
  logic [itp_pkg::SYM_W-1:0] out_symbol;
  logic                   has_symbol;
  logic                   run_last;
  logic                   expression_done;
  logic                   error;

  modport source (output valid, output out_symbol, output has_symbol, output run_last,
                  output expression_done, output error, input ready);
  modport sink   (input valid, input out_symbol, input has_symbol, input run_last,
                  input expression_done, input error, output ready);
endinterface

>>> hdl/itp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/infix_to_postfix_converter_unit.sv
// Shunting-yard infix-to-postfix converter with the operator stack held in a RAM.
// An operand, or the marker of an empty flush, is on the output register the cycle after its
// transfer; popped symbols follow from ST_EVAL, behind the stack RAM read.
// Operands, pushes and an empty flush finish in ST_IDLE, the only state that takes symbols;
// each popped symbol, the matching '(' and a flush's done marker need their own step; stalls add more.
// Reset clears the FSM, stack count, error latch and output valid; the stack RAM is not cleared.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  itp_sym_if.sink           symbols,
  itp_post_if.source        postfix
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  itp_pkg::state_t state, state_next;
  itp_pkg::op_t    op, op_next;
  itp_pkg::sym_t   cur, cur_next;
  itp_pkg::prec_t  cur_prec, cur_prec_next;
  itp_pkg::sym_t   top, top_next;
  logic [CNT_W-1:0] count, count_next;
  logic            err, err_next;

  logic            ov;
  itp_pkg::sym_t   o_sym;
  logic            o_has, o_last, o_done, o_err;

  logic            emit;
  itp_pkg::sym_t   e_sym;
  logic            e_has, e_last, e_done;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  itp_pkg::sym_t     ram_wdata, ram_rdata;

  logic             out_free;
  logic             accept;
  logic [CNT_W-1:0] cnt_m1, cnt_m2, cnt_m3;
  logic             cnt_one, cnt_zero, cnt_full;

  assign out_free = !ov || postfix.ready;
  assign accept   = symbols.valid && out_free && (state == itp_pkg::ST_IDLE);
  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign cnt_m3   = count - CNT_W'(3);
  assign cnt_one  = (count == CNT_W'(1));
  assign cnt_zero = (count == '0);
  assign cnt_full = (count == CNT_W'(STACK_DEPTH));

  itp_ram #(
    .WIDTH (itp_pkg::SYM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    itp_pkg::prec_t in_prec;
    logic           more;

    in_prec       = itp_pkg::prec_of(symbols.symbol);
    more          = 1'b0;
    state_next    = state;
    op_next       = op;
    cur_next      = cur;
    cur_prec_next = cur_prec;
    top_next      = top;
    count_next    = count;
    err_next      = err;
    emit          = 1'b0;
    e_sym         = '0;
    e_has         = 1'b0;
    e_last        = 1'b0;
    e_done        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = count[ADDR_W-1:0];
    ram_wdata     = symbols.symbol;
    ram_re        = 1'b0;
    ram_raddr     = cnt_m2[ADDR_W-1:0];
    symbols.ready = 1'b0;

    case (state)
      itp_pkg::ST_IDLE: begin
        symbols.ready = out_free;
        if (accept) begin
          cur_next      = symbols.symbol;
          cur_prec_next = in_prec;
          if (symbols.mode) begin
            if (cnt_zero) begin
              emit     = 1'b1;
              e_last   = 1'b1;
              e_done   = 1'b1;
              err_next = 1'b0;
            end else begin
              op_next    = itp_pkg::OP_FLUSH;
              ram_re     = 1'b1;
              state_next = itp_pkg::ST_EVAL;
            end
          end else if (itp_pkg::is_operand(symbols.symbol)) begin
            emit   = 1'b1;
            e_sym  = symbols.symbol;
            e_has  = 1'b1;
            e_last = 1'b1;
          end else if (symbols.symbol == itp_pkg::CH_CLOSE) begin
            if (cnt_zero) begin
              err_next = 1'b1;
            end else begin
              op_next    = itp_pkg::OP_CLOSE;
              ram_re     = 1'b1;
              state_next = itp_pkg::ST_EVAL;
            end
          end else if (symbols.symbol != itp_pkg::CH_OPEN && !cnt_zero &&
                       in_prec <= itp_pkg::prec_of(top)) begin
            op_next    = itp_pkg::OP_OPER;
            ram_re     = 1'b1;
            state_next = itp_pkg::ST_EVAL;
          end else if (cnt_full) begin
            // overflow: drop the character
            err_next = 1'b1;
          end else begin
            ram_we     = 1'b1;
            top_next   = symbols.symbol;
            count_next = count + CNT_W'(1);
          end
        end
      end

      itp_pkg::ST_EVAL: begin
        // top holds entry count-1, ram_rdata holds entry count-2
        ram_raddr = cnt_m3[ADDR_W-1:0];
        case (op)
          itp_pkg::OP_FLUSH: begin
            if (out_free) begin
              emit       = 1'b1;
              e_sym      = top;
              e_has      = 1'b1;
              count_next = cnt_m1;
              top_next   = ram_rdata;
              if (cnt_one) begin
                state_next = itp_pkg::ST_MARK;
              end else begin
                ram_re = 1'b1;
              end
            end
          end

          itp_pkg::OP_CLOSE: begin
            if (top == itp_pkg::CH_OPEN) begin
              // matching paren: discard it quietly
              count_next = cnt_m1;
              top_next   = ram_rdata;
              state_next = itp_pkg::ST_IDLE;
            end else if (out_free) begin
              emit       = 1'b1;
              e_sym      = top;
              e_has      = 1'b1;
              e_last     = cnt_one || (ram_rdata == itp_pkg::CH_OPEN);
              count_next = cnt_m1;
              top_next   = ram_rdata;
              if (cnt_one) begin
                err_next   = 1'b1;
                state_next = itp_pkg::ST_IDLE;
              end else begin
                ram_re = 1'b1;
              end
            end
          end

          itp_pkg::OP_OPER: begin
            if (out_free) begin
              more       = !cnt_one && (cur_prec <= itp_pkg::prec_of(ram_rdata));
              emit       = 1'b1;
              e_sym      = top;
              e_has      = 1'b1;
              e_last     = !more;
              count_next = cnt_m1;
              top_next   = ram_rdata;
              if (more) begin
                ram_re = 1'b1;
              end else begin
                // pop and push in one step: the freed slot takes the new operator
                ram_we     = 1'b1;
                ram_waddr  = cnt_m1[ADDR_W-1:0];
                ram_wdata  = cur;
                top_next   = cur;
                count_next = count;
                state_next = itp_pkg::ST_IDLE;
              end
            end
          end

          default: begin
            state_next = itp_pkg::ST_IDLE;
          end
        endcase
      end

      itp_pkg::ST_MARK: begin
        if (out_free) begin
          emit       = 1'b1;
          e_last     = 1'b1;
          e_done     = 1'b1;
          err_next   = 1'b0;
          count_next = '0;
          state_next = itp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = itp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itp_pkg::ST_IDLE;
      count <= '0;
      err   <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
      if (emit) begin
        ov <= 1'b1;
      end else if (postfix.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    cur      <= cur_next;
    cur_prec <= cur_prec_next;
    top      <= top_next;
    if (emit) begin
      o_sym  <= e_sym;
      o_has  <= e_has;
      o_last <= e_last;
      o_done <= e_done;
      o_err  <= err;
    end
  end

  assign postfix.valid           = ov;
  assign postfix.out_symbol      = o_sym;
  assign postfix.has_symbol      = o_has;
  assign postfix.run_last        = o_last;
  assign postfix.expression_done = o_done;
  assign postfix.error           = o_err;

endmodule

>>> hdl/itp_checker.sv
// Port-level assertions for the infix-to-postfix converter and their bind.
module itp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [itp_pkg::SYM_W-1:0] out_symbol,
  input logic                      has_symbol,
  input logic                      run_last,
  input logic                      expression_done
);

  // done marker closes its run and carries no character
  a_done_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && expression_done) |-> (run_last && !has_symbol && out_symbol == '0))
    else $error("done marker malformed");

  // the done marker is the only result without a character
  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_symbol) |-> expression_done)
    else $error("result without symbol that is not a done marker");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_symbol) && $stable(run_last)))
    else $error("output changed while stalled");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (postfix.valid),
  .out_ready       (postfix.ready),
  .out_symbol      (postfix.out_symbol),
  .has_symbol      (postfix.has_symbol),
  .run_last        (postfix.run_last),
  .expression_done (postfix.expression_done)
);

>>> sim/infix_to_postfix_converter_unit_checker.sv
// Scoreboard for the converter: mirrors the operator stack and checks every postfix transfer.
module infix_to_postfix_converter_unit_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  itp_sym_if   symbols,
  itp_post_if  postfix,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    itp_pkg::sym_t sym;
    logic          has;
    logic          last;
    logic          done;
    logic          err;
  } postfix_item_t;

  itp_pkg::sym_t op_stack [STACK_DEPTH];
  int unsigned   stack_fill = 0;
  logic          err_latch = 1'b0;
  postfix_item_t postfix_due [$];
  int            mismatches = 0;

  assign fail_count = mismatches;

  function automatic int rank(input itp_pkg::sym_t c);
    int r;
    case (c)
      itp_pkg::CH_CARET:                  r = 3;
      itp_pkg::CH_STAR, itp_pkg::CH_SLASH: r = 2;
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: r = 1;
      default:                            r = -1;
    endcase
    return r;
  endfunction

  function automatic logic alnum(input itp_pkg::sym_t c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
  endfunction

  // The error bit reflects the latch at the moment the result is produced.
  function automatic postfix_item_t result_of(input itp_pkg::sym_t c, input logic has,
                                              input logic done);
    postfix_item_t r;
    r.sym  = c;
    r.has  = has;
    r.last = 1'b0;
    r.done = done;
    r.err  = err_latch;
    return r;
  endfunction

  function automatic void push_op(input itp_pkg::sym_t c);
    if (stack_fill >= STACK_DEPTH) begin
      err_latch = 1'b1;
    end else begin
      op_stack[stack_fill] = c;
      stack_fill++;
    end
  endfunction

  task automatic convert_symbol(input logic m, input itp_pkg::sym_t c);
    postfix_item_t run [$];
    logic          matched;
    int            prio;
    matched = 1'b0;
    prio = rank(c);
    if (m) begin
      while (stack_fill > 0) begin
        stack_fill--;
        run.push_back(result_of(op_stack[stack_fill], 1'b1, 1'b0));
      end
      run.push_back(result_of('0, 1'b0, 1'b1));
      err_latch = 1'b0;
    end else if (alnum(c)) begin
      run.push_back(result_of(c, 1'b1, 1'b0));
    end else if (c == itp_pkg::CH_OPEN) begin
      push_op(c);
    end else if (c == itp_pkg::CH_CLOSE) begin
      // pop until the matching open paren, which is dropped silently
      while (stack_fill > 0 && !matched) begin
        stack_fill--;
        if (op_stack[stack_fill] == itp_pkg::CH_OPEN) matched = 1'b1;
        else run.push_back(result_of(op_stack[stack_fill], 1'b1, 1'b0));
      end
      if (!matched) err_latch = 1'b1;
    end else begin
      while (stack_fill > 0 && prio <= rank(op_stack[stack_fill-1])) begin
        stack_fill--;
        run.push_back(result_of(op_stack[stack_fill], 1'b1, 1'b0));
      end
      push_op(c);
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) postfix_due.push_back(run[i]);
  endtask

  function automatic void report(input string what, input logic has_want,
                                 input postfix_item_t want, input postfix_item_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      if (has_want)
        $display({"%0t %s: expected sym=%02h has=%b last=%b done=%b err=%b,",
                  " got sym=%02h has=%b last=%b done=%b err=%b"},
                 $time, what, want.sym, want.has, want.last, want.done, want.err,
                 seen.sym, seen.has, seen.last, seen.done, seen.err);
      else
        $display("%0t %s: got sym=%02h has=%b last=%b done=%b err=%b", $time, what,
                 seen.sym, seen.has, seen.last, seen.done, seen.err);
    end
  endfunction

  always @(posedge clk) begin
    postfix_item_t seen;
    postfix_item_t want;
    if (rst) begin
      postfix_due.delete();
      stack_fill = 0;
      err_latch = 1'b0;
    end else begin
      // outputs first: a transfer on the same edge as an input cannot come from it
      if (postfix.valid && postfix.ready) begin
        seen.sym  = postfix.out_symbol;
        seen.has  = postfix.has_symbol;
        seen.last = postfix.run_last;
        seen.done = postfix.expression_done;
        seen.err  = postfix.error;
        if (postfix_due.size() == 0) begin
          report("unexpected postfix transfer", 1'b0, seen, seen);
        end else begin
          want = postfix_due.pop_front();
          if (seen !== want) report("postfix mismatch", 1'b1, want, seen);
        end
      end
      if (symbols.valid && symbols.ready) convert_symbol(symbols.mode, symbols.symbol);
    end
    pending <= postfix_due.size();
  end

endmodule

>>> sim/infix_to_postfix_converter_unit_tb.sv
// Top of the converter testbench: clock, reset, infix stimulus, sink stalls and the verdict.
module infix_to_postfix_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 32;
  localparam int ITEM_TARGET = 180;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  itp_sym_if  sym_ch ();
  itp_post_if post_ch ();

  int fail_count;
  int pending;
  int items_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  int open_left   = 0;
  int roll;

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .symbols (sym_ch),
    .postfix (post_ch)
  );

  infix_to_postfix_converter_unit_checker #(
    .STACK_DEPTH(DEPTH)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .symbols    (sym_ch),
    .postfix    (post_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("infix_to_postfix_converter_unit verification failed");
      $finish;
    end
  end

  // Sink back-pressure: short stalls mostly, a few long ones, and stall-free stretches.
  always @(posedge clk) begin
    if (rst) begin
      post_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      post_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (open_left > 0) begin
      post_ch.ready <= 1'b1;
      open_left <= open_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        post_ch.ready <= 1'b1;
      end else if (roll < 85) begin
        post_ch.ready <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else if (roll < 95) begin
        post_ch.ready <= 1'b0;
        stall_left <= $urandom_range(3, 9);
      end else if (roll < 97) begin
        post_ch.ready <= 1'b0;
        stall_left <= $urandom_range(20, 40);
      end else begin
        post_ch.ready <= 1'b1;
        open_left <= $urandom_range(30, 80);
      end
    end
  end

  function automatic int idle_len();
    int r;
    int n;
    n = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50)      n = 0;
      else if (r < 82) n = $urandom_range(1, 3);
      else if (r < 92) n = $urandom_range(4, 8);
      else if (r < 96) n = $urandom_range(15, 40);
      else             burst_left = $urandom_range(20, 50);
    end
    return n;
  endfunction

  task automatic send_item(input logic m, input itp_pkg::sym_t c);
    int gap;
    sym_ch.valid  <= 1'b1;
    sym_ch.mode   <= m;
    sym_ch.symbol <= c;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
    items_sent++;
    gap = idle_len();
    if (gap > 0) begin
      sym_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender off until every expected postfix transfer has arrived.
  task automatic wait_drained();
    sym_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic itp_pkg::sym_t pick_operand();
    itp_pkg::sym_t c;
    case ($urandom_range(0, 2))
      0:       c = itp_pkg::sym_t'("A" + $urandom_range(0, 25));
      1:       c = itp_pkg::sym_t'("a" + $urandom_range(0, 25));
      default: c = itp_pkg::sym_t'("0" + $urandom_range(0, 9));
    endcase
    return c;
  endfunction

  function automatic itp_pkg::sym_t pick_operator();
    itp_pkg::sym_t c;
    case ($urandom_range(0, 4))
      0:       c = itp_pkg::CH_CARET;
      1:       c = itp_pkg::CH_STAR;
      2:       c = itp_pkg::CH_SLASH;
      3:       c = itp_pkg::CH_PLUS;
      default: c = itp_pkg::CH_MINUS;
    endcase
    return c;
  endfunction

  // Well-formed infix with random operands, operators and nesting, then end of expression.
  task automatic send_expression();
    int terms;
    int open_cnt;
    terms = $urandom_range(1, 6);
    open_cnt = 0;
    for (int t = 0; t < terms; t++) begin
      while (open_cnt < 4 && $urandom_range(0, 3) == 0) begin
        send_item(1'b0, itp_pkg::CH_OPEN);
        open_cnt++;
      end
      send_item(1'b0, pick_operand());
      while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        send_item(1'b0, itp_pkg::CH_CLOSE);
        open_cnt--;
      end
      if (t < terms - 1) send_item(1'b0, pick_operator());
    end
    while (open_cnt > 0) begin
      send_item(1'b0, itp_pkg::CH_CLOSE);
      open_cnt--;
    end
    send_item(1'b1, itp_pkg::sym_t'($urandom_range(0, 255)));
  endtask

  // Nest to between one below and three past the stack depth, so the overflow path is taken in most runs.
  task automatic send_deep();
    int pushes;
    int target;
    pushes = 0;
    target = $urandom_range(DEPTH - 1, DEPTH + 3);
    while (pushes < target) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(1'b0, pick_operand());
      end else begin
        send_item(1'b0, itp_pkg::CH_OPEN);
        pushes++;
      end
    end
    send_item(1'b0, pick_operator());
    send_item(1'b0, pick_operand());
    repeat ($urandom_range(0, 4)) send_item(1'b0, itp_pkg::CH_CLOSE);
    send_item(1'b1, itp_pkg::sym_t'($urandom_range(0, 255)));
  endtask

  // Random bytes, with stray parens and the odd end of expression.
  task automatic send_noise();
    int n;
    itp_pkg::sym_t c;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0:       c = itp_pkg::CH_CLOSE;
        1:       c = itp_pkg::CH_OPEN;
        default: c = itp_pkg::sym_t'($urandom_range(0, 255));
      endcase
      send_item($urandom_range(0, 9) == 0, c);
    end
  endtask

  initial begin
    string infix;
    int    kind;
    logic  deep_done;
    sym_ch.valid  <= 1'b0;
    sym_ch.mode   <= 1'b0;
    sym_ch.symbol <= '0;
    deep_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // all operators, operand range ends other than 'a', a paren pair and left-associative power
    infix = "A+b*(c-9)^z^0/Z";
    foreach (infix[i]) send_item(1'b0, itp_pkg::sym_t'(infix[i]));
    send_item(1'b1, itp_pkg::sym_t'(8'hA5));
    // stray close on an empty stack, unknown codes popping everything
    send_item(1'b0, itp_pkg::CH_CLOSE);
    send_item(1'b0, itp_pkg::CH_OPEN);
    send_item(1'b0, itp_pkg::sym_t'(8'hFF));
    send_item(1'b0, itp_pkg::CH_STAR);
    send_item(1'b0, itp_pkg::sym_t'(8'h00));
    send_item(1'b1, itp_pkg::sym_t'(8'hFF));
    // matched close on top, unmatched close after pops, open paren left for the flush
    send_item(1'b0, itp_pkg::CH_OPEN);
    send_item(1'b0, itp_pkg::CH_CLOSE);
    send_item(1'b0, itp_pkg::CH_PLUS);
    send_item(1'b0, itp_pkg::CH_CLOSE);
    send_item(1'b0, itp_pkg::CH_OPEN);
    send_item(1'b1, itp_pkg::sym_t'(8'h00));
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (!deep_done || kind < 3) begin
        send_deep();
        deep_done = 1'b1;
      end else if (kind < 75) begin
        send_expression();
      end else begin
        send_noise();
      end
      if (items_sent >= ITEM_TARGET / 2 && $urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("infix_to_postfix_converter_unit verification clean");
    else
      $display("infix_to_postfix_converter_unit verification failed");
    $finish;
  end

endmodule
